FILE: hdl/eot_pkg.sv
// ----------------------------------------------------------------------------
// eot_pkg: shared types and codes for the edge occurrence table
// Holds the operation and status codes and the layout of one stored entry.
// ----------------------------------------------------------------------------
package eot_pkg;

	// Operation codes carried by the opcode field of an input word.
	localparam logic [2:0] OP_APPEND  = 3'd0;
	localparam logic [2:0] OP_REM_KEY = 3'd1;
	localparam logic [2:0] OP_REM_IDX = 3'd2;
	localparam logic [2:0] OP_READ    = 3'd3;
	localparam logic [2:0] OP_CLEAR   = 3'd4;

	// Status codes returned with every result word.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// One table entry as it sits in memory (56 bits).
	typedef struct packed {
		logic [15:0] from;
		logic [15:0] dest;
		logic [15:0] edge_id;
		logic [7:0]  tag;
	} entry_t;

endpackage

FILE: hdl/edge_occurrence_table.sv
// ----------------------------------------------------------------------------
// edge_occurrence_table: bounded unordered table of edge occurrences
// Entries live in one synchronous memory. Removal moves the last entry into
// the freed slot; remove by key scans the table one entry per cycle.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_ready | opcode, node_from, node_dest, edge_id, index
//  out     | out_valid/out_ready | status, out_from, out_dest, out_edge,
//          |                     | out_tag, hit_index, entry_count
//
//  Every operation passes from decode to the response state; append, clear
//  and unused codes go directly, read and remove by index through one memory
//  read (S_READ, S_MOVE). Remove by key scans in S_SEARCH, one entry per cycle
//  from the single memory read port, up to the hit, then moves the last entry
//  in S_MOVE unless the hit is last; a missing key scans every entry.
//  Reset clears the entry count; memory contents are left as they are and
//  there is no clearing pass. Input is taken one word at a time while the
//  sequencer is idle; a finished result waits in the output register, and the
//  next word may be accepted meanwhile.
//
module edge_occurrence_table
	import eot_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [15:0] node_from,
	input  logic [15:0] node_dest,
	input  logic [15:0] edge_id,
	input  logic [7:0]  index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] out_from,
	output logic [15:0] out_dest,
	output logic [15:0] out_edge,
	output logic [7:0]  out_tag,
	output logic [7:0]  hit_index,
	output logic [8:0]  entry_count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 8) ? CW : 8;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_SEARCH = 6'b000100,
		S_MOVE   = 6'b001000,
		S_READ   = 6'b010000,
		S_RESP   = 6'b100000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   ptr_q;
	logic            out_valid_q;

	logic [2:0]      op_q;
	logic [15:0]     from_q;
	logic [15:0]     dest_q;
	logic [15:0]     edge_q;
	logic [7:0]      idx_q;

	logic [1:0]      res_status_q;
	logic [15:0]     res_from_q;
	logic [15:0]     res_dest_q;
	logic [15:0]     res_edge_q;
	logic [7:0]      res_tag_q;
	logic [7:0]      res_hit_q;

	logic [1:0]      status_q;
	logic [15:0]     out_from_q;
	logic [15:0]     out_dest_q;
	logic [15:0]     out_edge_q;
	logic [7:0]      out_tag_q;
	logic [7:0]      hit_index_q;
	logic [8:0]      entry_count_q;

	entry_t          entries_q [CAPACITY];
	entry_t          rd_data_q;

	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	entry_t          wr_data;

	logic [CW-1:0]   last_w;
	logic            full;
	logic            idx_ok;
	logic            idx_lt_last;
	logic            key_match;
	logic            srch_end;
	logic            move_needed;
	logic            resp_load;

	// Status flags derived from the count and the current memory word.
	assign last_w      = count_q - CW'(1);
	assign full        = count_q >= CW'(CAPACITY);
	assign idx_ok      = XW'(idx_q) < XW'(count_q);
	assign idx_lt_last = XW'(idx_q) < XW'(last_w);
	assign key_match   = (rd_data_q.from == from_q) && (rd_data_q.dest == dest_q);
	assign srch_end    = (CW'(ptr_q) + CW'(1)) >= count_q;
	assign move_needed = CW'(ptr_q) < last_w;
	assign resp_load   = (state_q == S_RESP) && (!out_valid_q || out_ready);

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign out_from    = out_from_q;
	assign out_dest    = out_dest_q;
	assign out_edge    = out_edge_q;
	assign out_tag     = out_tag_q;
	assign hit_index   = hit_index_q;
	assign entry_count = entry_count_q;

	// Memory port control. Reads and writes never share a cycle, and every
	// write retires before the next operation issues its first read, so no
	// forwarding path is needed.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		case (state_q)
			S_DECODE: begin
				case (op_q)
					OP_APPEND: begin
						if (!full) begin
							wr_en           = 1'b1;
							wr_addr         = AW'(count_q);
							wr_data.from    = from_q;
							wr_data.dest    = dest_q;
							wr_data.edge_id = edge_q;
							wr_data.tag     = 8'(count_q);
						end
					end
					OP_REM_KEY: begin
						if (count_q != '0) begin
							rd_en   = 1'b1;
							rd_addr = '0;
						end
					end
					OP_REM_IDX: begin
						if (idx_ok && idx_lt_last) begin
							rd_en   = 1'b1;
							rd_addr = AW'(last_w);
						end
					end
					OP_READ: begin
						if (idx_ok) begin
							rd_en   = 1'b1;
							rd_addr = AW'(idx_q);
						end
					end
					default: begin
					end
				endcase
			end
			S_SEARCH: begin
				if (key_match) begin
					if (move_needed) begin
						rd_en   = 1'b1;
						rd_addr = AW'(last_w);
					end
				end else if (!srch_end) begin
					rd_en   = 1'b1;
					rd_addr = ptr_q + AW'(1);
				end
			end
			S_MOVE: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q;
				wr_data = rd_data_q;
			end
			default: begin
			end
		endcase
	end

	// Entry memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= entries_q[rd_addr];
		end
	end

	// Sequencer, entry count, scan pointer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					case (op_q)
						OP_APPEND: begin
							if (!full) begin
								count_q <= count_q + CW'(1);
							end
							state_q <= S_RESP;
						end
						OP_REM_KEY: begin
							if (count_q != '0) begin
								ptr_q   <= '0;
								state_q <= S_SEARCH;
							end else begin
								state_q <= S_RESP;
							end
						end
						OP_REM_IDX: begin
							if (idx_ok && idx_lt_last) begin
								ptr_q   <= AW'(idx_q);
								state_q <= S_MOVE;
							end else begin
								if (idx_ok) begin
									count_q <= last_w;
								end
								state_q <= S_RESP;
							end
						end
						OP_READ: begin
							if (idx_ok) begin
								state_q <= S_READ;
							end else begin
								state_q <= S_RESP;
							end
						end
						OP_CLEAR: begin
							count_q <= '0;
							state_q <= S_RESP;
						end
						default: begin
							state_q <= S_RESP;
						end
					endcase
				end
				S_SEARCH: begin
					if (key_match) begin
						if (move_needed) begin
							state_q <= S_MOVE;
						end else begin
							count_q <= last_w;
							state_q <= S_RESP;
						end
					end else if (srch_end) begin
						state_q <= S_RESP;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				S_MOVE: begin
					count_q <= last_w;
					state_q <= S_RESP;
				end
				S_READ: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (resp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Captured input word, result fields and the output register.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q         <= opcode;
					from_q       <= node_from;
					dest_q       <= node_dest;
					edge_q       <= edge_id;
					idx_q        <= index;
					res_status_q <= ST_OK;
					res_from_q   <= '0;
					res_dest_q   <= '0;
					res_edge_q   <= '0;
					res_tag_q    <= '0;
					res_hit_q    <= '0;
				end
			end
			S_DECODE: begin
				case (op_q)
					OP_APPEND: begin
						if (full) begin
							res_status_q <= ST_FULL;
						end
					end
					OP_REM_KEY: begin
						if (count_q == '0) begin
							res_status_q <= ST_NOT_FOUND;
						end
					end
					OP_REM_IDX, OP_READ: begin
						if (!idx_ok) begin
							res_status_q <= ST_RANGE;
						end
					end
					default: begin
					end
				endcase
			end
			S_SEARCH: begin
				if (key_match) begin
					res_hit_q <= 8'(ptr_q);
				end else if (srch_end) begin
					res_status_q <= ST_NOT_FOUND;
				end
			end
			S_READ: begin
				res_from_q <= rd_data_q.from;
				res_dest_q <= rd_data_q.dest;
				res_edge_q <= rd_data_q.edge_id;
				res_tag_q  <= rd_data_q.tag;
			end
			S_RESP: begin
				if (resp_load) begin
					status_q      <= res_status_q;
					out_from_q    <= res_from_q;
					out_dest_q    <= res_dest_q;
					out_edge_q    <= res_edge_q;
					out_tag_q     <= res_tag_q;
					hit_index_q   <= res_hit_q;
					entry_count_q <= 9'(count_q);
				end
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	// The entry count never exceeds the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// The memory is never read and written in the same cycle.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("memory read and write overlap");

	// The scan pointer stays inside the filled part of the table.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> (CW'(ptr_q) < count_q))
		else $error("scan pointer beyond entry count");

	// A move only fills a slot below the last entry.
	a_move_below_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE) |-> move_needed)
		else $error("move target not below last entry");

	// An accepted word always starts the sequencer.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DECODE))
		else $error("accepted word did not start decode");
`endif

endmodule
